@@ rtl/core/cia_pkg.sv @@
// Shared types, constants and the divider step function of the complex integer ALU.
`timescale 1ns / 1ps
package cia_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   localparam int MID_DEPTH_DEF = 4;
   localparam int DIV_BITS      = 32;

   // Classified transaction passed from front to back.
   typedef struct packed {
      logic               is_div;
      logic signed [32:0] num_re;
      logic signed [32:0] num_im;
      logic [31:0]        den;
   } mid_entry_type;

   typedef struct packed {
      logic               is_div;
      logic               dz;
      logic               neg_re;
      logic               neg_im;
      logic signed [32:0] raw_re;
      logic signed [32:0] raw_im;
      logic [31:0]        den;
      logic [31:0]        num_re;
      logic [31:0]        num_im;
      logic [31:0]        rem_re;
      logic [31:0]        rem_im;
      logic [31:0]        quo_re;
      logic [31:0]        quo_im;
   } div_stage_type;

   // One restoring-division bit for both parts.
   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type t;
      logic [32:0]   r_re;
      logic [32:0]   r_im;
      logic [32:0]   d;
      t    = s;
      d    = {1'b0, s.den};
      r_re = {s.rem_re, s.num_re[31]};
      r_im = {s.rem_im, s.num_im[31]};
      t.num_re = {s.num_re[30:0], 1'b0};
      t.num_im = {s.num_im[30:0], 1'b0};
      if (r_re >= d) begin
         r_re = r_re - d;
         t.quo_re = {s.quo_re[30:0], 1'b1};
      end else begin
         t.quo_re = {s.quo_re[30:0], 1'b0};
      end
      if (r_im >= d) begin
         r_im = r_im - d;
         t.quo_im = {s.quo_im[30:0], 1'b1};
      end else begin
         t.quo_im = {s.quo_im[30:0], 1'b0};
      end
      t.rem_re = r_re[31:0];
      t.rem_im = r_im[31:0];
      return t;
   endfunction

endpackage

@@ rtl/core/complex_integer_alu_unit.sv @@
// Complex integer ALU: add, subtract, multiply and truncating divide of complex operands.
//
// Usage: the input side is a queue write port: req_push with req_op and the four
// signed 16-bit operand parts; a transaction is taken on an edge where req_push is
// high and req_full is low. The result side is a queue read port: while rsp_empty
// is low the oldest result sits on rsp_res_re, rsp_res_im and rsp_div_zero, and it
// is taken on an edge where rsp_pop is high.
// Path: 37 register stages, and the accepting edge loads the first: 2 front stages,
// the queue, 33 divider stages, 1 output register. Every operation takes the same
// path. Throughput: one transaction per cycle while the result side is not stalled.
// The path length is set by the bit-per-stage restoring divider: a load stage and 32 steps.
// A divide with a zero divisor returns zero parts and raises rsp_div_zero.
// Reset empties every stage and the queue; no result is pending after reset.
// When the receiver stalls, the back end holds; the front end keeps filling the
// queue between them, and req_full rises once the queue is full and the last front stage holds a transaction.
`timescale 1ns / 1ps
module complex_integer_alu_unit
   import cia_pkg::*;
#(
   parameter int MID_DEPTH = MID_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_a_re,
   input  logic signed [15:0] req_a_im,
   input  logic signed [15:0] req_b_re,
   input  logic signed [15:0] req_b_im,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [32:0] rsp_res_re,
   output logic signed [32:0] rsp_res_im,
   output logic               rsp_div_zero
);

   logic          mid_push, mid_full, mid_pop, mid_empty;
   mid_entry_type mid_wdata, mid_rdata;

   cia_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .op       (req_op),
      .a_re     (req_a_re),
      .a_im     (req_a_im),
      .b_re     (req_b_re),
      .b_im     (req_b_im),
      .full     (req_full),
      .mid_full (mid_full),
      .mid_push (mid_push),
      .mid_data (mid_wdata)
   );

   cia_queue #(.DEPTH(MID_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wdata),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_rdata),
      .empty     (mid_empty)
   );

   cia_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rdata),
      .mid_pop   (mid_pop),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .res_re    (rsp_res_re),
      .res_im    (rsp_res_im),
      .div_zero  (rsp_div_zero)
   );

endmodule

@@ rtl/core/cia_front.sv @@
// Front end: operand products and numerator/denominator formation.
`timescale 1ns / 1ps
module cia_front
   import cia_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [1:0]         op,
   input  logic signed [15:0] a_re,
   input  logic signed [15:0] a_im,
   input  logic signed [15:0] b_re,
   input  logic signed [15:0] b_im,
   output logic               full,
   input  logic               mid_full,
   output logic               mid_push,
   output mid_entry_type      mid_data
);

   logic               en;
   logic               s1_valid_ff;
   op_type             s1_op_ff;
   logic signed [15:0] s1_a_re_ff, s1_a_im_ff, s1_b_re_ff, s1_b_im_ff;
   logic signed [31:0] ac_ff, bd_ff, ad_ff, bc_ff, cc_ff, dd_ff;
   logic               s2_valid_ff;
   mid_entry_type      s2_ff;
   mid_entry_type      s2_in;
   logic signed [32:0] x_ac, x_bd, x_ad, x_bc;

   assign en       = !(s2_valid_ff && mid_full);
   assign full     = !en;
   assign mid_push = s2_valid_ff && en;
   assign mid_data = s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= push;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff   <= op_type'(op);
         s1_a_re_ff <= a_re;
         s1_a_im_ff <= a_im;
         s1_b_re_ff <= b_re;
         s1_b_im_ff <= b_im;
         ac_ff      <= a_re * b_re;
         bd_ff      <= a_im * b_im;
         ad_ff      <= a_re * b_im;
         bc_ff      <= a_im * b_re;
         cc_ff      <= b_re * b_re;
         dd_ff      <= b_im * b_im;
         s2_ff      <= s2_in;
      end
   end

   always_comb begin
      x_ac = {ac_ff[31], ac_ff};
      x_bd = {bd_ff[31], bd_ff};
      x_ad = {ad_ff[31], ad_ff};
      x_bc = {bc_ff[31], bc_ff};
      s2_in.is_div = 1'b0;
      s2_in.den    = 32'($unsigned(cc_ff)) + 32'($unsigned(dd_ff));
      unique case (s1_op_ff)
         OP_ADD: begin
            s2_in.num_re = {{17{s1_a_re_ff[15]}}, s1_a_re_ff} + {{17{s1_b_re_ff[15]}}, s1_b_re_ff};
            s2_in.num_im = {{17{s1_a_im_ff[15]}}, s1_a_im_ff} + {{17{s1_b_im_ff[15]}}, s1_b_im_ff};
         end
         OP_SUB: begin
            s2_in.num_re = {{17{s1_a_re_ff[15]}}, s1_a_re_ff} - {{17{s1_b_re_ff[15]}}, s1_b_re_ff};
            s2_in.num_im = {{17{s1_a_im_ff[15]}}, s1_a_im_ff} - {{17{s1_b_im_ff[15]}}, s1_b_im_ff};
         end
         OP_MUL: begin
            s2_in.num_re = x_ac - x_bd;
            s2_in.num_im = x_ad + x_bc;
         end
         OP_DIV: begin
            s2_in.is_div = 1'b1;
            s2_in.num_re = x_ac + x_bd;
            s2_in.num_im = x_bc - x_ad;
         end
         default: begin
            s2_in.num_re = '0;
            s2_in.num_im = '0;
         end
      endcase
   end

endmodule

@@ rtl/core/cia_queue.sv @@
// Small queue decoupling front end from back end.
`timescale 1ns / 1ps
module cia_queue
   import cia_pkg::*;
#(
   parameter int DEPTH = MID_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  mid_entry_type push_data,
   output logic          full,
   input  logic          pop,
   output mid_entry_type pop_data,
   output logic          empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mid_entry_type mem [0:DEPTH-1];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count out of range");
`endif

endmodule

@@ rtl/core/cia_back.sv @@
// Back end: pipelined restoring divider, result select and output register.
`timescale 1ns / 1ps
module cia_back
   import cia_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               mid_empty,
   input  mid_entry_type      mid_data,
   output logic               mid_pop,
   input  logic               pop,
   output logic               empty,
   output logic signed [32:0] res_re,
   output logic signed [32:0] res_im,
   output logic               div_zero
);

   logic               en;
   logic               valid_ff [0:DIV_BITS];
   div_stage_type      stage_ff [0:DIV_BITS];
   div_stage_type      load_in;
   logic [32:0]        neg_re, neg_im;
   logic               out_valid_ff;
   logic signed [32:0] res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic               dz_ff, dz_in;
   div_stage_type      last;

   assign en      = !out_valid_ff || pop;
   assign mid_pop = en && !mid_empty;
   assign empty   = !out_valid_ff;
   assign res_re  = res_re_ff;
   assign res_im  = res_im_ff;
   assign div_zero = dz_ff;

   always_comb begin
      neg_re         = 33'(-mid_data.num_re);
      neg_im         = 33'(-mid_data.num_im);
      load_in        = '0;
      load_in.is_div = mid_data.is_div;
      load_in.dz     = mid_data.is_div && (mid_data.den == '0);
      load_in.neg_re = mid_data.num_re[32];
      load_in.neg_im = mid_data.num_im[32];
      load_in.raw_re = mid_data.num_re;
      load_in.raw_im = mid_data.num_im;
      load_in.den    = mid_data.den;
      load_in.num_re = mid_data.num_re[32] ? neg_re[31:0] : mid_data.num_re[31:0];
      load_in.num_im = mid_data.num_im[32] ? neg_im[31:0] : mid_data.num_im[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= !mid_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= load_in;
      end
   end

   for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[k] <= div_step(stage_ff[k-1]);
         end
      end
   end

   always_comb begin
      last = stage_ff[DIV_BITS];
      dz_in = last.dz;
      if (!last.is_div) begin
         res_re_in = last.raw_re;
         res_im_in = last.raw_im;
      end else if (last.dz) begin
         res_re_in = '0;
         res_im_in = '0;
      end else begin
         res_re_in = last.neg_re ? 33'(-{1'b0, last.quo_re}) : {1'b0, last.quo_re};
         res_im_in = last.neg_im ? 33'(-{1'b0, last.quo_im}) : {1'b0, last.quo_im};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[DIV_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         dz_ff     <= dz_in;
      end
   end

`ifndef SYNTHESIS
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && dz_ff) |-> (res_re_ff == '0 && res_im_ff == '0))
      else $error("divide by zero with nonzero result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !pop) |=> (out_valid_ff && $stable(res_re_ff) && $stable(res_im_ff)))
      else $error("stalled result changed");
   a_pop_gate: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> en)
      else $error("queue popped while back end stalled");
`endif

endmodule

@@ dv/complex_integer_alu_unit_checker.sv @@
// Checker for the complex integer ALU: predicts results and compares them in order.
`timescale 1ns / 1ps
module complex_integer_alu_unit_checker
   import cia_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_a_re,
   input  logic signed [15:0] req_a_im,
   input  logic signed [15:0] req_b_re,
   input  logic signed [15:0] req_b_im,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic signed [32:0] rsp_res_re,
   input  logic signed [32:0] rsp_res_im,
   input  logic               rsp_div_zero,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic signed [32:0] re;
      logic signed [32:0] im;
      logic               dz;
   } cplx_result_type;

   cplx_result_type expected_results[$];

   function automatic cplx_result_type compute_cplx(input logic [1:0] op,
         input logic signed [15:0] ar, input logic signed [15:0] ai,
         input logic signed [15:0] br, input logic signed [15:0] bi);
      cplx_result_type r;
      longint a, b, c, d, den, re, im;
      a = ar;
      b = ai;
      c = br;
      d = bi;
      re = 0;
      im = 0;
      r.dz = 1'b0;
      case (op_type'(op))
         OP_ADD: begin
            re = a + c;
            im = b + d;
         end
         OP_SUB: begin
            re = a - c;
            im = b - d;
         end
         OP_MUL: begin
            re = a * c - b * d;
            im = a * d + b * c;
         end
         default: begin
            den = c * c + d * d;
            if (den == 0) r.dz = 1'b1;
            else begin
               re = (a * c + b * d) / den;
               im = (b * c - a * d) / den;
            end
         end
      endcase
      r.re = re[32:0];
      r.im = im[32:0];
      return r;
   endfunction

   assign pending = expected_results.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      cplx_result_type e;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transaction re=%0d im=%0d dz=%0b", $time,
                  rsp_res_re, rsp_res_im, rsp_div_zero);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_results.pop_front();
               if (e.re !== rsp_res_re || e.im !== rsp_res_im || e.dz !== rsp_div_zero) begin
                  $display("%0t: mismatch expected re=%0d im=%0d dz=%0b actual re=%0d im=%0d dz=%0b",
                     $time, e.re, e.im, e.dz, rsp_res_re, rsp_res_im, rsp_div_zero);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_push && !req_full)
            expected_results.push_back(compute_cplx(req_op, req_a_re, req_a_im,
               req_b_re, req_b_im));
      end
   end

endmodule

@@ dv/complex_integer_alu_unit_tb.sv @@
// Testbench top for the complex integer ALU: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module complex_integer_alu_unit_tb;
   import cia_pkg::*;

   localparam int LATENCY   = 36;
   localparam int MAX_CYCLE = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [1:0]         req_op = OP_ADD;
   logic signed [15:0] req_a_re = '0;
   logic signed [15:0] req_a_im = '0;
   logic signed [15:0] req_b_re = '0;
   logic signed [15:0] req_b_im = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [32:0] rsp_res_re;
   logic signed [32:0] rsp_res_im;
   logic               rsp_div_zero;
   int                 fail_count;
   int                 pending;
   int                 send_idle_pct = 0;
   int                 stall_pct = 0;
   bit                 hold_off = 1'b0;
   int                 cycle_count = 0;

   always #6 clock = ~clock;

   complex_integer_alu_unit dut (.*);

   complex_integer_alu_unit_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset || hold_off) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic signed [15:0] pick_operand();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3: return 16'(int'($urandom_range(8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_cplx(input logic [1:0] op, input logic signed [15:0] ar,
         input logic signed [15:0] ai, input logic signed [15:0] br,
         input logic signed [15:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_op   <= op;
      req_a_re <= ar;
      req_a_im <= ai;
      req_b_re <= br;
      req_b_im <= bi;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input int n);
      logic [1:0] op;
      for (int i = 0; i < n; i++) begin
         op = 2'($urandom);
         if (op == OP_DIV && $urandom_range(9) == 0)
            send_cplx(op, pick_operand(), pick_operand(), '0, '0);
         else
            send_cplx(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
      end
   endtask

   initial begin
      logic signed [15:0] ext[3];
      ext[0] = 16'sh8000;
      ext[1] = 16'sh7fff;
      ext[2] = 16'sh0000;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int op = 0; op < 4; op++) begin
         send_cplx(2'(op), ext[0], ext[0], ext[0], ext[0]);
         send_cplx(2'(op), ext[1], ext[1], ext[1], ext[1]);
         send_cplx(2'(op), ext[1], ext[0], ext[0], ext[1]);
         send_cplx(2'(op), ext[0], ext[1], ext[2], ext[2]);
      end
      send_cplx(OP_DIV, 16'sd7, -16'sd7, 16'sd2, 16'sd0);
      send_cplx(OP_DIV, -16'sd7, 16'sd7, 16'sd0, -16'sd2);
      send_cplx(OP_DIV, 16'sd1, 16'sd1, 16'sh7fff, 16'sh8000);
      send_cplx(OP_DIV, 16'sh8000, 16'sh8000, -16'sd1, 16'sd0);
      send_random(200);
      send_idle_pct = 54;
      send_random(150);
      send_idle_pct = 0;
      stall_pct = 54;
      send_random(150);
      send_idle_pct = 9;
      stall_pct = 9;
      send_random(150);
      fork
         begin
            hold_off = 1'b1;
            repeat (150) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            send_idle_pct = 0;
            send_random(100);
         end
      join
      stall_pct = 0;
      send_random(100);
      req_push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/cia_pkg.sv
rtl/core/cia_front.sv
rtl/core/cia_queue.sv
rtl/core/cia_back.sv
rtl/core/complex_integer_alu_unit.sv
dv/complex_integer_alu_unit_checker.sv
dv/complex_integer_alu_unit_tb.sv
